// ----- src/tlcs_pkg.sv -----
package tlcs_pkg;

  // capture sizes
  localparam int MAX_LINE     = 64;
  localparam int NUM_SLOTS    = 6;
  localparam int PREFIX_LEN   = 6;
  localparam int NUM_PREFIXES = 7;

  localparam int BUF_AW     = $clog2(MAX_LINE);
  localparam int LEN_W      = $clog2(MAX_LINE + 1);
  localparam int SLOT_DEPTH = NUM_SLOTS * MAX_LINE;
  localparam int SLOT_AW    = $clog2(SLOT_DEPTH);
  localparam int CMP_W      = (LEN_W > 6) ? LEN_W : 6;
  localparam int SLOT_LEN_MAX = 63;

  localparam logic [2:0] NO_SLOT = 3'd6;

  // character codes
  localparam logic [7:0] CHAR_O  = 8'h4F;
  localparam logic [7:0] CHAR_L  = 8'h4C;
  localparam logic [7:0] CHAR_D  = 8'h44;
  localparam logic [7:0] CHAR_SP = 8'h20;
  localparam logic [7:0] CHAR_NL = 8'h0A;

  // header matcher position
  typedef enum logic [2:0] {
    HDR_SEEK,
    HDR_O,
    HDR_L,
    HDR_D,
    HDR_CAPTURE
  } hdr_e;

  // top level sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_DRAIN,
    ST_EMIT
  } seq_e;

  // outcome of one received byte
  typedef struct packed {
    logic             done;
    logic             dropped;
    logic [2:0]       slot;
    logic [LEN_W-1:0] len;
  } line_evt_t;

  // line buffer write request
  typedef struct packed {
    logic              we;
    logic [BUF_AW-1:0] addr;
    logic [7:0]        data;
  } buf_wr_t;

  // position prefix strings, first character in the top byte
  function automatic logic [8*PREFIX_LEN-1:0] prefix_str(input logic [2:0] p);
    logic [8*PREFIX_LEN-1:0] s;
    begin
      unique case (p)
        3'd0:    s = "00 01 ";
        3'd1:    s = "56 05 ";
        3'd2:    s = "48 05 ";
        3'd3:    s = "80 05 ";
        3'd4:    s = "72 01 ";
        3'd5:    s = "48 06 ";
        3'd6:    s = "40 07 ";
        default: s = '0;
      endcase
      return s;
    end
  endfunction

  function automatic logic [7:0] prefix_char(input logic [2:0] p, input logic [2:0] k);
    logic [8*PREFIX_LEN-1:0] s;
    begin
      s = prefix_str(p);
      return s[(PREFIX_LEN - 1 - int'(k)) * 8 +: 8];
    end
  endfunction

  // both satellite prefixes share one slot
  function automatic logic [2:0] prefix_slot(input logic [2:0] p);
    logic [2:0] s;
    begin
      unique case (p)
        3'd0:    s = 3'd0;
        3'd1:    s = 3'd1;
        3'd2:    s = 3'd1;
        3'd3:    s = 3'd2;
        3'd4:    s = 3'd3;
        3'd5:    s = 3'd4;
        3'd6:    s = 3'd5;
        default: s = NO_SLOT;
      endcase
      return s;
    end
  endfunction

endpackage

// ----- src/tlcs_ram.sv -----
module tlcs_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/tlcs_capture.sv -----
module tlcs_capture (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               byte_valid_i,
  input  logic [7:0]         byte_i,
  output tlcs_pkg::line_evt_t evt_o,
  output tlcs_pkg::buf_wr_t  buf_wr_o
);
  import tlcs_pkg::*;

  hdr_e                    hdr_q, hdr_d;
  logic [LEN_W-1:0]        cnt_q, cnt_d;
  logic [NUM_PREFIXES-1:0] match_q, match_d;
  logic [2:0]              hit_slot;

  // header position, line length and prefix match flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q   <= HDR_SEEK;
      cnt_q   <= '0;
      match_q <= '0;
    end else begin
      hdr_q   <= hdr_d;
      cnt_q   <= cnt_d;
      match_q <= match_d;
    end
  end

  // lowest numbered matching prefix wins
  always_comb begin
    hit_slot = NO_SLOT;
    for (int p = NUM_PREFIXES - 1; p >= 0; p--) begin
      if (match_q[p]) begin
        hit_slot = prefix_slot(3'(p));
      end
    end
  end

  // header matcher and capture
  always_comb begin
    hdr_d         = hdr_q;
    cnt_d         = cnt_q;
    match_d       = match_q;
    evt_o.done    = 1'b0;
    evt_o.dropped = 1'b0;
    evt_o.slot    = NO_SLOT;
    evt_o.len     = '0;
    buf_wr_o.we   = 1'b0;
    buf_wr_o.addr = cnt_q[BUF_AW-1:0];
    buf_wr_o.data = byte_i;
    if (byte_valid_i) begin
      unique case (hdr_q)
        HDR_SEEK: begin
          if (byte_i == CHAR_O) hdr_d = HDR_O;
        end
        HDR_O: begin
          hdr_d = (byte_i == CHAR_L) ? HDR_L : HDR_SEEK;
        end
        HDR_L: begin
          hdr_d = (byte_i == CHAR_D) ? HDR_D : HDR_SEEK;
        end
        HDR_D: begin
          if (byte_i == CHAR_SP) begin
            hdr_d   = HDR_CAPTURE;
            cnt_d   = '0;
            match_d = '1;
          end else begin
            hdr_d = HDR_SEEK;
          end
        end
        HDR_CAPTURE: begin
          if (cnt_q == LEN_W'(MAX_LINE)) begin
            // buffer full: abandon the line
            evt_o.dropped = 1'b1;
            hdr_d         = HDR_SEEK;
          end else begin
            buf_wr_o.we = 1'b1;
            cnt_d       = cnt_q + 1'b1;
            if (cnt_q < LEN_W'(PREFIX_LEN)) begin
              for (int p = 0; p < NUM_PREFIXES; p++) begin
                match_d[p] = match_q[p] & (byte_i == prefix_char(3'(p), cnt_q[2:0]));
              end
            end
            if (byte_i == CHAR_NL) begin
              evt_o.done = 1'b1;
              hdr_d      = HDR_SEEK;
              if (cnt_q >= LEN_W'(PREFIX_LEN)) begin
                evt_o.slot = hit_slot;
                evt_o.len  = cnt_q - LEN_W'(PREFIX_LEN - 1);
              end
            end
          end
        end
        default: hdr_d = HDR_SEEK;
      endcase
    end
  end

  // capture starts with every prefix still possible
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (byte_valid_i && hdr_q == HDR_D && byte_i == CHAR_SP) |=> (match_q == '1 && cnt_q == '0))
    else $error("capture did not start cleanly");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hdr_q != HDR_CAPTURE) |-> !buf_wr_o.we)
    else $error("line buffer written outside capture");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_o.slot != NO_SLOT |-> (evt_o.done && evt_o.len != '0))
    else $error("slot chosen without a complete line");

endmodule

// ----- src/tagged_line_capture_and_sort.sv -----
// channel | direction | valid       | stall       | payload
// in      | to block  | in_valid_i  | in_stall_o  | action_i rx_byte_i slot_select_i char_index_i
// out     | from blk  | out_valid_o | out_stall_i | line_done_o line_slot_o line_dropped_o
//         |           |             |             | read_char_o slot_length_o
//
// a received byte goes IDLE, EMIT; a slot read goes IDLE, READ (slot store read port), EMIT
// a line that lands in a slot goes IDLE, COPY once per byte after the prefix, DRAIN, EMIT, with the
// one-byte-a-cycle copy from the line buffer into the slot store
// one item is processed at a time; the next is taken while a result waits in the output register
// reset is asynchronous, active low, and clears the matcher, the lengths and all handshake state
module tagged_line_capture_and_sort (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       action_i,
  input  logic [7:0] rx_byte_i,
  input  logic [2:0] slot_select_i,
  input  logic [5:0] char_index_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       line_done_o,
  output logic [2:0] line_slot_o,
  output logic       line_dropped_o,
  output logic [7:0] read_char_o,
  output logic [5:0] slot_length_o
);
  import tlcs_pkg::*;

  typedef struct packed {
    logic       line_done;
    logic [2:0] line_slot;
    logic       line_dropped;
    logic [7:0] read_char;
    logic [5:0] slot_length;
  } result_t;

  seq_e              state_q, state_d;
  result_t           res_q, res_d;
  result_t           out_q, out_d;
  logic              out_valid_q, out_valid_d;
  logic [2:0]        sel_q, sel_d;
  logic [5:0]        idx_q, idx_d;
  logic [2:0]        copy_slot_q, copy_slot_d;
  logic [LEN_W-1:0]  copy_end_q, copy_end_d;
  logic [LEN_W-1:0]  cp_q, cp_d;
  logic              wr_pend_q, wr_pend_d;
  logic [BUF_AW-1:0] wr_off_q, wr_off_d;
  logic [LEN_W-1:0]  slot_len_q [NUM_SLOTS];
  logic [LEN_W-1:0]  slot_len_d [NUM_SLOTS];

  logic              in_accept;
  line_evt_t         evt;
  buf_wr_t           buf_wr;
  logic [BUF_AW-1:0] buf_raddr;
  logic [7:0]        buf_rdata;
  logic              slot_we;
  logic [SLOT_AW-1:0] slot_waddr;
  logic [SLOT_AW-1:0] slot_raddr;
  logic [7:0]        slot_rdata;
  logic [LEN_W-1:0]  rd_len;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  // header matcher and line capture
  tlcs_capture u_capture (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (in_accept && !action_i),
    .byte_i       (rx_byte_i),
    .evt_o        (evt),
    .buf_wr_o     (buf_wr)
  );

  // line buffer
  tlcs_ram #(.Width(8), .Depth(MAX_LINE)) u_line_buf (
    .clk_i   (clk_i),
    .we_i    (buf_wr.we),
    .waddr_i (buf_wr.addr),
    .wdata_i (buf_wr.data),
    .raddr_i (buf_raddr),
    .rdata_o (buf_rdata)
  );

  // slot text store, one row of MAX_LINE bytes per slot
  assign slot_we    = wr_pend_q;
  assign slot_waddr = SLOT_AW'(copy_slot_q) * SLOT_AW'(MAX_LINE) + SLOT_AW'(wr_off_q);
  assign slot_raddr = SLOT_AW'(slot_select_i) * SLOT_AW'(MAX_LINE) + SLOT_AW'(char_index_i);

  tlcs_ram #(.Width(8), .Depth(SLOT_DEPTH)) u_slot_text (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (buf_rdata),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      wr_pend_q   <= 1'b0;
      for (int s = 0; s < NUM_SLOTS; s++) begin
        slot_len_q[s] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      wr_pend_q   <= wr_pend_d;
      slot_len_q  <= slot_len_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    res_q       <= res_d;
    out_q       <= out_d;
    sel_q       <= sel_d;
    idx_q       <= idx_d;
    copy_slot_q <= copy_slot_d;
    copy_end_q  <= copy_end_d;
    cp_q        <= cp_d;
    wr_off_q    <= wr_off_d;
  end

  assign rd_len = slot_len_q[sel_q];

  // sequencer: read, line copy and result hand-off
  always_comb begin
    state_d     = state_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    sel_d       = sel_q;
    idx_d       = idx_q;
    copy_slot_d = copy_slot_q;
    copy_end_d  = copy_end_q;
    cp_d        = cp_q;
    wr_pend_d   = 1'b0;
    wr_off_d    = wr_off_q;
    slot_len_d  = slot_len_q;
    buf_raddr   = cp_q[BUF_AW-1:0];
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (action_i) begin
            sel_d   = slot_select_i;
            idx_d   = char_index_i;
            state_d = ST_READ;
          end else begin
            res_d.line_done    = evt.done;
            res_d.line_slot    = evt.slot;
            res_d.line_dropped = evt.dropped;
            res_d.read_char    = '0;
            res_d.slot_length  = '0;
            if (evt.slot != NO_SLOT) begin
              slot_len_d[evt.slot] = evt.len;
              copy_slot_d = evt.slot;
              copy_end_d  = evt.len + LEN_W'(PREFIX_LEN);
              cp_d        = LEN_W'(PREFIX_LEN);
              state_d     = ST_COPY;
            end else begin
              state_d = ST_EMIT;
            end
          end
        end
      end
      ST_READ: begin
        res_d.line_done    = 1'b0;
        res_d.line_slot    = NO_SLOT;
        res_d.line_dropped = 1'b0;
        res_d.read_char    = '0;
        res_d.slot_length  = '0;
        if (sel_q < 3'(NUM_SLOTS)) begin
          res_d.slot_length = (CMP_W'(rd_len) > CMP_W'(SLOT_LEN_MAX)) ?
                              6'(SLOT_LEN_MAX) : 6'(rd_len);
          if (CMP_W'(idx_q) < CMP_W'(rd_len)) begin
            res_d.read_char = slot_rdata;
          end
        end
        state_d = ST_EMIT;
      end
      ST_COPY: begin
        // read one byte, write it into the slot on the next cycle
        wr_pend_d = 1'b1;
        wr_off_d  = BUF_AW'(cp_q - LEN_W'(PREFIX_LEN));
        cp_d      = cp_q + 1'b1;
        if (cp_q == copy_end_q - 1'b1) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign line_done_o    = out_q.line_done;
  assign line_slot_o    = out_q.line_slot;
  assign line_dropped_o = out_q.line_dropped;
  assign read_char_o    = out_q.read_char;
  assign slot_length_o  = out_q.slot_length;

  // last copied byte is still to be written when the copy drains
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> wr_pend_q)
    else $error("copy drained without a pending write");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COPY) |-> (cp_q < copy_end_q && copy_slot_q < 3'(NUM_SLOTS)))
    else $error("copy pointer or slot out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && line_slot_o != NO_SLOT) |-> (line_done_o && !line_dropped_o))
    else $error("slot reported without a completed line");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (read_char_o != '0 || slot_length_o != '0)) |-> !line_done_o)
    else $error("read fields set on a receive transaction");

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import tlcs_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 80;
  localparam int ITEM_TARGET  = 2000;

  // one result transaction
  typedef struct packed {
    logic       done;
    logic [2:0] slot;
    logic       dropped;
    logic [7:0] rchar;
    logic [5:0] rlen;
  } outcome_t;

  typedef enum {ROW_READ, ROW_BYTE, ROW_RAW, ROW_LINE, ROW_FILL} row_e;

  // directed stimulus row; want is only used where typed is set
  typedef struct {
    row_e       kind;
    int         tag;
    string      txt;
    logic [7:0] fill;
    int         count;
    logic [2:0] sel;
    logic [5:0] idx;
    bit         typed;
    outcome_t   want;
  } row_t;

  localparam outcome_t QUIET_OUT = '{1'b0, NO_SLOT, 1'b0, 8'h00, 6'd0};

  // position tags, first character in the top byte, and the slot each one fills
  localparam logic [47:0] POS_TAG [NUM_PREFIXES] = '{
    "00 01 ", "56 05 ", "48 05 ", "80 05 ", "72 01 ", "48 06 ", "40 07 "
  };
  localparam logic [2:0] TAG_SLOT [NUM_PREFIXES] = '{
    3'd0, 3'd1, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5
  };
  localparam logic [7:0] HDR_CHARS [4] = '{CHAR_O, CHAR_L, CHAR_D, CHAR_SP};

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic       action_i;
  logic [7:0] rx_byte_i;
  logic [2:0] slot_select_i;
  logic [5:0] char_index_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic       line_done_o;
  logic [2:0] line_slot_o;
  logic       line_dropped_o;
  logic [7:0] read_char_o;
  logic [5:0] slot_length_o;

  tagged_line_capture_and_sort dut (.*);

  // predictor state
  hdr_e       hdr_pos;
  logic [7:0] cap_buf [MAX_LINE];
  int         cap_len;
  logic [7:0] slot_chars [NUM_SLOTS][MAX_LINE];
  bit         slot_seen [NUM_SLOTS][MAX_LINE];
  int         slot_len [NUM_SLOTS];

  outcome_t   sort_q [$];
  int         fails;
  int         accepted;
  int         counted;
  int         n_sorted;
  int         n_unsorted;
  int         n_dropped;
  int         n_reads;
  int         quiet;
  int         out_hold;
  bit         calm;
  row_t       plan [];

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int pick_wait();
    return calm ? 0 : int'($urandom_range(0, 15));
  endfunction

  // expected outcome of one accepted transaction, advancing the predictor state
  function automatic outcome_t sort_predict(input logic act, input logic [7:0] b,
                                            input logic [2:0] sel, input logic [5:0] idx);
    outcome_t    r;
    int          hit;
    int          n;
    logic [47:0] head;
    r   = QUIET_OUT;
    hit = -1;
    if (act) begin
      n_reads++;
      if (sel < NUM_SLOTS) begin
        r.rlen = (slot_len[sel] > SLOT_LEN_MAX) ? 6'(SLOT_LEN_MAX) : 6'(slot_len[sel]);
        if (int'(idx) < slot_len[sel]) r.rchar = slot_chars[sel][idx];
      end
    end else begin
      case (hdr_pos)
        HDR_SEEK: if (b == CHAR_O) hdr_pos = HDR_O;
        HDR_O:    hdr_pos = (b == CHAR_L) ? HDR_L : HDR_SEEK;
        HDR_L:    hdr_pos = (b == CHAR_D) ? HDR_D : HDR_SEEK;
        HDR_D: begin
          if (b == CHAR_SP) begin
            cap_len = 0;
            hdr_pos = HDR_CAPTURE;
          end else begin
            hdr_pos = HDR_SEEK;
          end
        end
        default: begin
          if (cap_len >= MAX_LINE) begin
            // buffer full: the line is abandoned
            r.dropped = 1'b1;
            hdr_pos   = HDR_SEEK;
            n_dropped++;
          end else begin
            cap_buf[cap_len] = b;
            cap_len++;
            if (b == CHAR_NL) begin
              r.done  = 1'b1;
              hdr_pos = HDR_SEEK;
              // lines longer than the tag are sorted by their first six characters
              if (cap_len > PREFIX_LEN) begin
                head = {cap_buf[0], cap_buf[1], cap_buf[2], cap_buf[3], cap_buf[4], cap_buf[5]};
                for (int t = 0; t < NUM_PREFIXES && hit < 0; t++) begin
                  if (head == POS_TAG[t]) hit = t;
                end
              end
              if (hit >= 0) begin
                r.slot = TAG_SLOT[hit];
                n = cap_len - PREFIX_LEN;
                for (int k = 0; k < n; k++) begin
                  slot_chars[r.slot][k] = cap_buf[PREFIX_LEN + k];
                  slot_seen[r.slot][k]  = 1'b1;
                end
                slot_len[r.slot] = n;
                n_sorted++;
              end else begin
                n_unsorted++;
              end
            end
          end
        end
      endcase
    end
    return r;
  endfunction

  // one input transaction: random gap, then hold valid until taken
  task automatic send_item(input logic act, input logic [7:0] b, input logic [2:0] sel,
                           input logic [5:0] idx, input bit typed, input outcome_t want);
    int       gap;
    outcome_t got;
    gap = pick_wait();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    action_i      <= act;
    rx_byte_i     <= b;
    slot_select_i <= sel;
    char_index_i  <= idx;
    do @(posedge clk_i); while (in_stall_o);
    // bytes the matcher simply skips do not count toward the target
    if (act || hdr_pos != HDR_SEEK || b == CHAR_O) counted++;
    got = sort_predict(act, b, sel, idx);
    sort_q.push_back(typed ? want : got);
    accepted++;
    if (accepted % 150 == 0) calm = ($urandom_range(0, 3) == 0);
  endtask

  task automatic put_byte(input logic [7:0] b);
    send_item(1'b0, b, 3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)), 1'b0, QUIET_OUT);
  endtask

  // slot read, steered away from entries that were never written
  task automatic put_read(input logic [2:0] sel, input logic [5:0] idx);
    if (sel < NUM_SLOTS && int'(idx) >= slot_len[sel] && !slot_seen[sel][idx]) begin
      if (slot_len[sel] > 0) idx = 6'($urandom_range(0, slot_len[sel] - 1));
      else sel = 3'(NUM_SLOTS + $urandom_range(0, 1));
    end
    send_item(1'b1, 8'($urandom), sel, idx, 1'b0, QUIET_OUT);
  endtask

  task automatic put_header();
    for (int j = 0; j < 4; j++) put_byte(HDR_CHARS[j]);
  endtask

  task automatic put_tag(input int t);
    for (int k = 0; k < PREFIX_LEN; k++) put_byte(POS_TAG[t][(PREFIX_LEN - 1 - k) * 8 +: 8]);
  endtask

  task automatic field_check(input string what, input logic [7:0] e, input logic [7:0] a);
    if (a !== e) begin
      $display("%0t: %s expected %0d actual %0d", $time, what, e, a);
      fails++;
    end
  endtask

  // result side: sample at the rising edge, stall changes at the falling edge
  initial begin
    outcome_t exp_out;
    out_stall_i = 1'b0;
    out_hold    = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (sort_q.size() == 0) begin
          $display("%0t: result transaction with nothing expected", $time);
          fails++;
        end else begin
          exp_out = sort_q.pop_front();
          field_check("line_done", 8'(exp_out.done), 8'(line_done_o));
          field_check("line_slot", 8'(exp_out.slot), 8'(line_slot_o));
          field_check("line_dropped", 8'(exp_out.dropped), 8'(line_dropped_o));
          field_check("read_char", exp_out.rchar, read_char_o);
          field_check("slot_length", 8'(exp_out.rlen), 8'(slot_length_o));
        end
        out_hold = pick_wait();
      end
      @(negedge clk_i);
      out_stall_i <= (out_hold != 0);
      if (out_hold != 0) out_hold--;
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding",
               $time, quiet, sort_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // stimulus
  initial begin
    int         pick;
    int         kind;
    int         body;
    int         t;
    int         k;
    int         n;
    logic [7:0] c;
    logic [2:0] sel;
    logic [5:0] idx;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    action_i      = 1'b0;
    rx_byte_i     = 8'h00;
    slot_select_i = 3'd0;
    char_index_i  = 6'd0;
    hdr_pos       = HDR_SEEK;
    cap_len       = 0;
    calm          = 1'b0;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      slot_len[s] = 0;
      for (int j = 0; j < MAX_LINE; j++) slot_seen[s][j] = 1'b0;
    end
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part
    plan = '{
      '{ROW_READ, 0, "", 8'h00, 0, 3'd6, 6'd0, 1'b1, QUIET_OUT},
      '{ROW_READ, 0, "", 8'h00, 0, 3'd7, 6'd63, 1'b1, QUIET_OUT},
      '{ROW_BYTE, 0, "", 8'h00, 0, 3'd0, 6'd0, 1'b1, QUIET_OUT},
      '{ROW_BYTE, 0, "", 8'hFF, 0, 3'd7, 6'd63, 1'b1, QUIET_OUT},
      // repeated first header char is not taken as a fresh start
      '{ROW_RAW, 0, "OOLD 00 01 x\n", 8'h00, 0, 3'd0, 6'd0, 1'b0, QUIET_OUT},
      '{ROW_RAW, 0, "OLX", 8'h00, 0, 3'd0, 6'd0, 1'b0, QUIET_OUT},
      '{ROW_RAW, 0, "OLDX", 8'h00, 0, 3'd0, 6'd0, 1'b0, QUIET_OUT},
      '{ROW_LINE, 0, "12:34:56\n", 8'h00, 0, 3'd0, 6'd0, 1'b0, QUIET_OUT},
      '{ROW_LINE, 1, "7\n", 8'h00, 0, 3'd0, 6'd0, 1'b0, QUIET_OUT},
      '{ROW_LINE, 2, "9\n", 8'h00, 0, 3'd0, 6'd0, 1'b0, QUIET_OUT},
      '{ROW_LINE, 3, "1\n", 8'h00, 0, 3'd0, 6'd0, 1'b0, QUIET_OUT},
      '{ROW_LINE, 4, "JO31\n", 8'h00, 0, 3'd0, 6'd0, 1'b0, QUIET_OUT},
      '{ROW_LINE, 5, "51.5\n", 8'h00, 0, 3'd0, 6'd0, 1'b0, QUIET_OUT},
      '{ROW_LINE, 6, "7.1\n", 8'h00, 0, 3'd0, 6'd0, 1'b0, QUIET_OUT},
      // short line, bare tag plus newline, unknown tag
      '{ROW_RAW, 0, "OLD 00 01\n", 8'h00, 0, 3'd0, 6'd0, 1'b0, QUIET_OUT},
      '{ROW_LINE, 0, "\n", 8'h00, 0, 3'd0, 6'd0, 1'b0, QUIET_OUT},
      '{ROW_RAW, 0, "OLD 99 99 abc\n", 8'h00, 0, 3'd0, 6'd0, 1'b0, QUIET_OUT},
      // zero bytes as data, a full buffer, one byte too many
      '{ROW_FILL, 4, "", 8'h00, 3, 3'd0, 6'd0, 1'b0, QUIET_OUT},
      '{ROW_FILL, 5, "", 8'hFF, 57, 3'd0, 6'd0, 1'b0, QUIET_OUT},
      '{ROW_FILL, 6, "", 8'h55, 58, 3'd0, 6'd0, 1'b0, QUIET_OUT},
      '{ROW_READ, 0, "", 8'h00, 0, 3'd0, 6'd0, 1'b0, QUIET_OUT},
      '{ROW_READ, 0, "", 8'h00, 0, 3'd0, 6'd5, 1'b0, QUIET_OUT},
      '{ROW_READ, 0, "", 8'h00, 0, 3'd4, 6'd57, 1'b0, QUIET_OUT},
      '{ROW_READ, 0, "", 8'h00, 0, 3'd3, 6'd1, 1'b0, QUIET_OUT},
      '{ROW_READ, 0, "", 8'h00, 0, 3'd1, 6'd0, 1'b0, QUIET_OUT}
    };
    foreach (plan[r]) begin
      case (plan[r].kind)
        ROW_READ: send_item(1'b1, 8'h00, plan[r].sel, plan[r].idx, plan[r].typed, plan[r].want);
        ROW_BYTE: send_item(1'b0, plan[r].fill, plan[r].sel, plan[r].idx, plan[r].typed,
                            plan[r].want);
        ROW_RAW: begin
          for (int j = 0; j < plan[r].txt.len(); j++) put_byte(plan[r].txt[j]);
        end
        ROW_LINE: begin
          put_header();
          put_tag(plan[r].tag);
          for (int j = 0; j < plan[r].txt.len(); j++) put_byte(plan[r].txt[j]);
        end
        default: begin
          put_header();
          put_tag(plan[r].tag);
          repeat (plan[r].count) put_byte(plan[r].fill);
          put_byte(CHAR_NL);
        end
      endcase
    end

    // random part, mostly well-formed lines with random content
    while (counted < ITEM_TARGET) begin
      pick = $urandom_range(0, 19);
      if (pick < 11) begin
        kind = $urandom_range(0, 9);
        body = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 57) : $urandom_range(0, 12);
        if ($urandom_range(0, 15) == 0) body = $urandom_range(58, 60);
        put_header();
        if (kind < NUM_PREFIXES) begin
          put_tag(kind);
        end else if (kind == 7) begin
          repeat (PREFIX_LEN) put_byte(8'($urandom));
        end else if (kind == 8) begin
          // tag with one bit flipped
          t = $urandom_range(0, NUM_PREFIXES - 1);
          k = $urandom_range(0, PREFIX_LEN - 1);
          for (int j = 0; j < PREFIX_LEN; j++) begin
            c = POS_TAG[t][(PREFIX_LEN - 1 - j) * 8 +: 8];
            if (j == k) c = c ^ (8'h01 << $urandom_range(0, 7));
            put_byte(c);
          end
        end else begin
          body = $urandom_range(0, PREFIX_LEN - 1);
        end
        repeat (body) put_byte(8'($urandom));
        put_byte(CHAR_NL);
      end else if (pick < 16) begin
        repeat ($urandom_range(1, 6)) begin
          sel = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7))
                                             : 3'($urandom_range(0, NUM_SLOTS - 1));
          if (sel < NUM_SLOTS && slot_len[sel] > 0 && $urandom_range(0, 1) == 1)
            idx = 6'($urandom_range(0, slot_len[sel] - 1));
          else
            idx = 6'($urandom_range(0, 63));
          put_read(sel, idx);
        end
      end else if (pick < 18) begin
        // header broken after a few good characters
        n = $urandom_range(1, 3);
        for (int j = 0; j < n; j++) put_byte(HDR_CHARS[j]);
        put_byte(8'($urandom));
      end else begin
        repeat ($urandom_range(1, 5)) begin
          k = $urandom_range(0, 5);
          put_byte((k < 4) ? HDR_CHARS[k] : ((k == 4) ? CHAR_NL : 8'($urandom)));
        end
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sort_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d transactions in: %0d lines sorted into slots, %0d short or unmatched",
             accepted, n_sorted, n_unsorted);
    $display("%0d lines dropped on overflow, %0d slot reads, %0d mismatches",
             n_dropped, n_reads, fails);
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
